### src/sbi_pkg.sv
// package for the segment/box intersection block
// shared constants, register indexes, outcome codes and the classification tag
// no dependencies
`default_nettype none

package sbi_pkg;

    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int EPS_W           = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MAX_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MAX_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_MAX_Z = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PAR_EPS   = 3'd6;

    localparam logic [1:0] OUT_BOTH_IN  = 2'd0;
    localparam logic [1:0] OUT_ONE_IN   = 2'd1;
    localparam logic [1:0] OUT_SLAB_HIT = 2'd2;
    localparam logic [1:0] OUT_SLAB_MISS = 2'd3;

    typedef struct packed {
        logic       early;
        logic [1:0] code;
        logic       hit;
        logic       pmiss;
        logic [2:0] par;
    } sbi_tag_t;

    localparam int TAG_W = $bits(sbi_tag_t);

endpackage

`default_nettype wire

### src/sbi_front.sv
// front end: configuration registers, box bounds, inside tests, slab numerators
// two register stages feeding the queue; depends on sbi_pkg
`default_nettype none

module sbi_front
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0][COORD_WIDTH-1:0]   s_start,
    input  wire logic [2:0][COORD_WIDTH-1:0]   s_end,
    input  wire logic [2:0][COORD_WIDTH-1:0]   s_pos,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic [2:0][COORD_WIDTH-1:0]        push_nmin,
    output logic [2:0][COORD_WIDTH-1:0]        push_nmax,
    output logic [2:0][COORD_WIDTH-1:0]        push_d,
    output sbi_tag_t                           push_tag
);

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_sum(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic sub);
        logic [W:0] ax;
        logic [W:0] bx;
        logic [W:0] r;
        ax = {a[W-1], a};
        bx = {b[W-1], b};
        r  = sub ? (ax - bx) : (ax + bx);
        if (r[W] != r[W-1]) begin
            return r[W] ? MIN_V : MAX_V;
        end
        return r[W-1:0];
    endfunction

    logic [2:0][W-1:0]  ext_min_reg;
    logic [2:0][W-1:0]  ext_max_reg;
    logic [EPS_W-1:0]   eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_min_reg <= '0;
            ext_max_reg <= '0;
            eps_reg     <= EPS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_EXT_MIN_X: ext_min_reg[0] <= cfg_wdata;
                REG_EXT_MIN_Y: ext_min_reg[1] <= cfg_wdata;
                REG_EXT_MIN_Z: ext_min_reg[2] <= cfg_wdata;
                REG_EXT_MAX_X: ext_max_reg[0] <= cfg_wdata;
                REG_EXT_MAX_Y: ext_max_reg[1] <= cfg_wdata;
                REG_EXT_MAX_Z: ext_max_reg[2] <= cfg_wdata;
                REG_PAR_EPS:   eps_reg        <= cfg_wdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic v1_reg;
    logic v2_reg;
    logic adv1;
    logic adv2;

    assign adv2       = !v2_reg || push_ready;
    assign adv1       = !v1_reg || adv2;
    assign s_ready    = adv1;
    assign push_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    // stage 1: bounds and direction
    logic [2:0][W-1:0] s1_s_reg;
    logic [2:0][W-1:0] s1_e_reg;
    logic [2:0][W-1:0] s1_bmin_reg;
    logic [2:0][W-1:0] s1_bmax_reg;
    logic [2:0][W-1:0] s1_d_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            for (int a = 0; a < 3; a++) begin
                s1_s_reg[a]    <= s_start[a];
                s1_e_reg[a]    <= s_end[a];
                s1_bmin_reg[a] <= sat_sum(s_pos[a], ext_min_reg[a], 1'b0);
                s1_bmax_reg[a] <= sat_sum(s_pos[a], ext_max_reg[a], 1'b0);
                s1_d_reg[a]    <= sat_sum(s_end[a], s_start[a], 1'b1);
            end
        end
    end

    // stage 2: classification and numerators
    sbi_tag_t          tag_next;
    logic [2:0][W-1:0] nmin_next;
    logic [2:0][W-1:0] nmax_next;

    always_comb begin
        logic in_s;
        logic in_e;
        logic [W-1:0] dmag;
        in_s = 1'b1;
        in_e = 1'b1;
        tag_next = '0;
        for (int a = 0; a < 3; a++) begin
            if (!($signed(s1_s_reg[a]) > $signed(s1_bmin_reg[a]) &&
                  $signed(s1_s_reg[a]) < $signed(s1_bmax_reg[a]))) in_s = 1'b0;
            if (!($signed(s1_e_reg[a]) > $signed(s1_bmin_reg[a]) &&
                  $signed(s1_e_reg[a]) < $signed(s1_bmax_reg[a]))) in_e = 1'b0;
            dmag = s1_d_reg[a][W-1] ? (~s1_d_reg[a] + 1'b1) : s1_d_reg[a];
            tag_next.par[a] = (s1_d_reg[a] == '0) || (dmag < W'(eps_reg));
            if (tag_next.par[a] &&
                ($signed(s1_s_reg[a]) < $signed(s1_bmin_reg[a]) ||
                 $signed(s1_s_reg[a]) > $signed(s1_bmax_reg[a]))) tag_next.pmiss = 1'b1;
            nmin_next[a] = sat_sum(s1_bmin_reg[a], s1_s_reg[a], 1'b1);
            nmax_next[a] = sat_sum(s1_bmax_reg[a], s1_s_reg[a], 1'b1);
        end
        tag_next.early = in_s || in_e;
        tag_next.hit   = in_s != in_e;
        tag_next.code  = (in_s && in_e) ? OUT_BOTH_IN : OUT_ONE_IN;
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            push_nmin <= nmin_next;
            push_nmax <= nmax_next;
            push_d    <= s1_d_reg;
            push_tag  <= tag_next;
        end
    end

endmodule

`default_nettype wire

### src/sbi_fifo.sv
// short queue between the front end and the divider back end
// depends on sbi_pkg for its default depth
`default_nettype none

module sbi_fifo
    import sbi_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire logic [DW-1:0] wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output logic [DW-1:0]      rd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd) count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

### src/sbi_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating signed result
// computes num / den with FRAC_BITS fraction bits; depends on sbi_pkg
`default_nettype none

module sbi_div
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [COORD_WIDTH-1:0] num,
    input  wire logic [COORD_WIDTH-1:0] den,
    output logic [COORD_WIDTH-1:0]      quot
);

    localparam int W = COORD_WIDTH;
    localparam int N = COORD_WIDTH + FRAC_BITS;

    logic [N:0][W-1:0] rem_reg;
    logic [N:0][W-1:0] quo_reg;
    logic [N:0][W-1:0] dvd_reg;
    logic [N:0][W-1:0] ud_reg;
    logic [N:0]        neg_reg;
    logic [N:0]        ovf_reg;

    // magnitudes
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            ovf_reg[0] <= 1'b0;
            dvd_reg[0] <= num[W-1] ? (~num + 1'b1) : num;
            ud_reg[0]  <= den[W-1] ? (~den + 1'b1) : den;
            neg_reg[0] <= num[W-1] ^ den[W-1];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [W-1:0] shifted;
        logic         ge;
        assign shifted = {rem_reg[i][W-2:0], dvd_reg[i][W-1]};
        assign ge      = shifted >= ud_reg[i];
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? (shifted - ud_reg[i]) : shifted;
                quo_reg[i+1] <= {quo_reg[i][W-2:0], ge};
                ovf_reg[i+1] <= ovf_reg[i] | quo_reg[i][W-1];
                dvd_reg[i+1] <= {dvd_reg[i][W-2:0], 1'b0};
                ud_reg[i+1]  <= ud_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic [W-1:0] maxmag;
    logic [W-1:0] qsat;

    always_comb begin
        maxmag = neg_reg[N] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        qsat   = (ovf_reg[N] || quo_reg[N] > maxmag) ? maxmag : quo_reg[N];
    end

    always_ff @(posedge aclk) begin
        if (en) quot <= neg_reg[N] ? (~qsat + 1'b1) : qsat;
    end

endmodule

`default_nettype wire

### src/sbi_back.sv
// back end: six slab dividers, interval narrowing, final decision, output register
// depends on sbi_pkg and sbi_div
`default_nettype none

module sbi_back
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [2:0][COORD_WIDTH-1:0]  in_nmin,
    input  wire logic [2:0][COORD_WIDTH-1:0]  in_nmax,
    input  wire logic [2:0][COORD_WIDTH-1:0]  in_d,
    input  wire sbi_tag_t                     in_tag,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic [1:0]                        m_outcome
);

    localparam int W   = COORD_WIDTH;
    localparam int LAT = COORD_WIDTH + FRAC_BITS + 2;
    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_V = W'(1) << FRAC_BITS;

    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_ready;
    assign in_ready = en;
    assign m_valid  = m_valid_reg;

    logic [2:0][W-1:0] t1;
    logic [2:0][W-1:0] t2;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        sbi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_min (
            .aclk (aclk),
            .en   (en),
            .num  (in_nmin[a]),
            .den  (in_d[a]),
            .quot (t1[a])
        );
        sbi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_max (
            .aclk (aclk),
            .en   (en),
            .num  (in_nmax[a]),
            .den  (in_d[a]),
            .quot (t2[a])
        );
    end

    // tag line alongside the dividers
    sbi_tag_t       tag_reg [LAT];
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < LAT; k++) tag_reg[k] <= tag_reg[k-1];
        end
    end

    // order each slab
    logic [2:0][W-1:0] lo_reg;
    logic [2:0][W-1:0] hi_reg;
    sbi_tag_t          x_tag_reg;
    logic              x_vld_reg;

    // interval
    logic [W-1:0] tmin_reg;
    logic [W-1:0] tmax_reg;
    sbi_tag_t     y_tag_reg;
    logic         y_vld_reg;

    logic [W-1:0] tmin_next;
    logic [W-1:0] tmax_next;

    always_comb begin
        tmin_next = MIN_V;
        tmax_next = MAX_V;
        for (int a = 0; a < 3; a++) begin
            if ($signed(lo_reg[a]) > $signed(tmin_next)) tmin_next = lo_reg[a];
            if ($signed(hi_reg[a]) < $signed(tmax_next)) tmax_next = hi_reg[a];
        end
    end

    logic miss;
    assign miss = y_tag_reg.pmiss || ($signed(tmin_reg) > $signed(tmax_reg)) ||
                  tmax_reg[W-1] || ($signed(tmin_reg) > $signed(ONE_V));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_vld_reg   <= 1'b0;
            y_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            x_vld_reg   <= vld_reg[LAT-1];
            y_vld_reg   <= x_vld_reg;
            m_valid_reg <= y_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (tag_reg[LAT-1].par[a]) begin
                    lo_reg[a] <= MIN_V;
                    hi_reg[a] <= MAX_V;
                end else if ($signed(t1[a]) > $signed(t2[a])) begin
                    lo_reg[a] <= t2[a];
                    hi_reg[a] <= t1[a];
                end else begin
                    lo_reg[a] <= t1[a];
                    hi_reg[a] <= t2[a];
                end
            end
            x_tag_reg <= tag_reg[LAT-1];
            tmin_reg  <= tmin_next;
            tmax_reg  <= tmax_next;
            y_tag_reg <= x_tag_reg;
            if (y_tag_reg.early) begin
                m_hit     <= y_tag_reg.hit;
                m_outcome <= y_tag_reg.code;
            end else begin
                m_hit     <= !miss;
                m_outcome <= miss ? OUT_SLAB_MISS : OUT_SLAB_HIT;
            end
        end
    end

endmodule

`default_nettype wire

### src/segment_box_intersect.sv
// segment against axis-aligned box test, top level
// a result follows its input through the front end, the queue and the bit-per-stage slab dividers;
// one segment accepted every cycle while the queue has room and the output is not stalled
// reset (synchronous, active low) empties all stages and the queue, extents to 0, epsilon to 66
// depends on sbi_pkg, sbi_front, sbi_fifo, sbi_back
`default_nettype none

module segment_box_intersect
    import sbi_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [COORD_WIDTH-1:0] cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COORD_WIDTH-1:0] s_start_x,
    input  wire logic [COORD_WIDTH-1:0] s_start_y,
    input  wire logic [COORD_WIDTH-1:0] s_start_z,
    input  wire logic [COORD_WIDTH-1:0] s_end_x,
    input  wire logic [COORD_WIDTH-1:0] s_end_y,
    input  wire logic [COORD_WIDTH-1:0] s_end_z,
    input  wire logic [COORD_WIDTH-1:0] s_box_pos_x,
    input  wire logic [COORD_WIDTH-1:0] s_box_pos_y,
    input  wire logic [COORD_WIDTH-1:0] s_box_pos_z,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_hit,
    output logic [1:0]                  m_outcome
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = 9 * W + TAG_W;

    logic              push_valid;
    logic              push_ready;
    logic [2:0][W-1:0] push_nmin;
    logic [2:0][W-1:0] push_nmax;
    logic [2:0][W-1:0] push_d;
    sbi_tag_t          push_tag;

    logic              pop_valid;
    logic              pop_ready;
    logic [DW-1:0]     pop_data;
    logic [2:0][W-1:0] pop_nmin;
    logic [2:0][W-1:0] pop_nmax;
    logic [2:0][W-1:0] pop_d;
    sbi_tag_t          pop_tag;

    sbi_front #(.COORD_WIDTH(W)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_start    ({s_start_z, s_start_y, s_start_x}),
        .s_end      ({s_end_z, s_end_y, s_end_x}),
        .s_pos      ({s_box_pos_z, s_box_pos_y, s_box_pos_x}),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_nmin  (push_nmin),
        .push_nmax  (push_nmax),
        .push_d     (push_d),
        .push_tag   (push_tag)
    );

    sbi_fifo #(.DW(DW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_tag, push_d, push_nmax, push_nmin}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    assign {pop_tag, pop_d, pop_nmax, pop_nmin} = pop_data;

    sbi_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_nmin   (pop_nmin),
        .in_nmax   (pop_nmax),
        .in_d      (pop_d),
        .in_tag    (pop_tag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .m_outcome (m_outcome)
    );

endmodule

`default_nettype wire

### src/sbi_checker.sv
// port-level checks for segment_box_intersect, attached by bind
// depends on sbi_pkg
`default_nettype none

module sbi_checker
    import sbi_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_hit,
    input wire logic [1:0] m_outcome
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_outcome))
        else $error("result changed while stalled");

    // offered input stays offered until its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input dropped before transfer");

    // hit flag agrees with the outcome code
    a_hit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_outcome == OUT_ONE_IN || m_outcome == OUT_SLAB_HIT)))
        else $error("hit does not match outcome");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // nothing comes out right after reset without any input transfer
    a_no_early: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> !m_valid)
        else $error("result without input transfer");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_hit     (m_hit),
    .m_outcome (m_outcome)
);

`default_nettype wire
